// File: src/psat_pkg.sv
// Shared constants, types and tables for the parent-space affine transform unit.
package psat_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int TRIG_ITERATIONS = 16;
    localparam int IO_FRAC         = 16;

    localparam int POS_W      = 32;
    localparam int SKEW_IN_W  = 20;
    localparam int SKEW_OUT_W = 19;
    localparam int SCALE_W    = 24;
    localparam int SKD_W      = 23;

    localparam int ANG_W        = 36;
    localparam int CW           = 34;
    localparam int ATAN_ENTRIES = 24;
    localparam int ITER_W       = $clog2(ATAN_ENTRIES);
    localparam int ANG_SHIFT    = 30 - IO_FRAC;
    localparam int TRIG_SHIFT   = 30 - FRAC_BITS;

    localparam int TRIG_W  = FRAC_BITS + 3;
    localparam int PROD_W  = SCALE_W + TRIG_W;
    localparam int COEF_W  = 26;
    localparam int DIFF_W  = POS_W + 1;
    localparam int DET_W   = 50;
    localparam int NUM_W   = 58;
    localparam int QBITS   = POS_W + IO_FRAC + 1;
    localparam int LATENCY = TRIG_ITERATIONS + QBITS + 7;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [SKD_W-1:0] SKEW_PI     = 23'sd205887;
    localparam logic signed [SKD_W-1:0] SKEW_TWO_PI = 23'sd411775;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [DET_W-1:0] r;
        logic [QBITS-1:0] nq;
        logic [DET_W-1:0] dd;
    } t_div;

    function automatic logic signed [CW-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            5'd0:    v = 34'sh3243F6A8;
            5'd1:    v = 34'sh1DAC6705;
            5'd2:    v = 34'sh0FADBAFC;
            5'd3:    v = 34'sh07F56EA6;
            5'd4:    v = 34'sh03FEAB76;
            5'd5:    v = 34'sh01FFD55B;
            5'd6:    v = 34'sh00FFFAAA;
            5'd7:    v = 34'sh007FFF55;
            5'd8:    v = 34'sh003FFFEA;
            5'd9:    v = 34'sh001FFFFD;
            5'd10:   v = 34'sh000FFFFF;
            5'd11:   v = 34'sh0007FFFF;
            5'd12:   v = 34'sh0003FFFF;
            5'd13:   v = 34'sh0001FFFF;
            5'd14:   v = 34'sh0000FFFF;
            5'd15:   v = 34'sh00007FFF;
            5'd16:   v = 34'sh00003FFF;
            5'd17:   v = 34'sh00001FFF;
            5'd18:   v = 34'sh00000FFF;
            5'd19:   v = 34'sh000007FF;
            5'd20:   v = 34'sh000003FF;
            5'd21:   v = 34'sh000001FF;
            5'd22:   v = 34'sh000000FF;
            5'd23:   v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/psat_cordic_cell.sv
// One registered CORDIC rotation step.
module psat_cordic_cell (
    input  logic                      i_clk,
    input  logic [psat_pkg::ITER_W-1:0] i_iter,
    input  psat_pkg::t_cordic         i_vec,
    output psat_pkg::t_cordic         o_vec
);
    import psat_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    t_cordic              n_vec;
    t_cordic              r_vec;

    assign xs = $signed(i_vec.x) >>> i_iter;
    assign ys = $signed(i_vec.y) >>> i_iter;
    assign at = atan_entry(i_iter);

    always_comb begin
        if (!i_vec.z[CW-1]) begin
            n_vec.x = $signed(i_vec.x) - ys;
            n_vec.y = $signed(i_vec.y) + xs;
            n_vec.z = $signed(i_vec.z) - at;
        end else begin
            n_vec.x = $signed(i_vec.x) + ys;
            n_vec.y = $signed(i_vec.y) - xs;
            n_vec.z = $signed(i_vec.z) + at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;

endmodule

// File: src/psat_div_cell.sv
// One registered restoring-division step producing one quotient bit.
module psat_div_cell (
    input  logic           i_clk,
    input  psat_pkg::t_div i_div,
    output psat_pkg::t_div o_div
);
    import psat_pkg::*;

    logic [DET_W:0] trial;
    logic           ge;
    t_div           n_div;
    t_div           r_div;

    assign trial = {i_div.r, i_div.nq[QBITS-1]};
    assign ge    = (trial >= {1'b0, i_div.dd});

    always_comb begin
        n_div.dd = i_div.dd;
        n_div.nq = {i_div.nq[QBITS-2:0], ge};
        if (ge) begin
            n_div.r = DET_W'(trial - {1'b0, i_div.dd});
        end else begin
            n_div.r = trial[DET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_div = r_div;

endmodule

// File: src/parent_space_affine_transform_unit.sv
// Top level of the parent-space affine transform unit.
//
// A transfer into the block happens at a rising edge with start high and busy
// low; busy is always low, so one item may be taken in every cycle. Each item
// carries a child position and skews and a parent scale, skew and position.
// The block builds sine and cosine of both parent skews in two rows of CORDIC
// cells, forms the parent matrix, its determinant and the two numerators, and
// divides in two rows of restoring-division cells, one quotient bit per cell.
// The result appears on the o_ ports for exactly one cycle with o_valid high,
// once the item has passed the CORDIC rows, the matrix stages, the division
// rows and the output register.
// Throughput is one item per cycle; latency is set by the CORDIC row length
// and the 49 quotient bits of the division rows.
// A zero determinant raises o_singular and saturates the positions by the
// sign of their numerators. Synchronous reset clears every valid flag in the
// pipeline, dropping items in flight. The receiver cannot hold results off.
module parent_space_affine_transform_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [psat_pkg::POS_W-1:0]     i_child_x,
    input  logic signed [psat_pkg::POS_W-1:0]     i_child_y,
    input  logic signed [psat_pkg::SKEW_IN_W-1:0] i_child_skew_x,
    input  logic signed [psat_pkg::SKEW_IN_W-1:0] i_child_skew_y,
    input  logic signed [psat_pkg::SCALE_W-1:0]   i_parent_scale_x,
    input  logic signed [psat_pkg::SCALE_W-1:0]   i_parent_scale_y,
    input  logic signed [psat_pkg::SKEW_IN_W-1:0] i_parent_skew_x,
    input  logic signed [psat_pkg::SKEW_IN_W-1:0] i_parent_skew_y,
    input  logic signed [psat_pkg::POS_W-1:0]     i_parent_x,
    input  logic signed [psat_pkg::POS_W-1:0]     i_parent_y,
    output logic                                  o_valid,
    output logic signed [psat_pkg::POS_W-1:0]     o_local_x,
    output logic signed [psat_pkg::POS_W-1:0]     o_local_y,
    output logic signed [psat_pkg::SKEW_OUT_W-1:0] o_local_skew_x,
    output logic signed [psat_pkg::SKEW_OUT_W-1:0] o_local_skew_y,
    output logic                                  o_singular
);
    import psat_pkg::*;

    typedef struct packed {
        logic                     negx;
        logic                     negy;
        logic signed [SCALE_W-1:0] sx;
        logic signed [SCALE_W-1:0] sy;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [SKD_W-1:0]  skx;
        logic signed [SKD_W-1:0]  sky;
    } t_side;

    typedef struct packed {
        logic                    sing;
        logic                    qnegx;
        logic                    qnegy;
        logic                    ovfx;
        logic                    ovfy;
        logic                    numnegx;
        logic                    numnzx;
        logic                    numnegy;
        logic                    numnzy;
        logic signed [SKD_W-1:0] skx;
        logic signed [SKD_W-1:0] sky;
    } t_tail;

    typedef struct packed {
        logic                  neg;
        logic signed [CW-1:0]  z;
    } t_angle;

    function automatic t_angle angle_prep(input logic signed [SKEW_IN_W-1:0] ang);
        logic signed [ANG_W-1:0] z;
        t_angle                  res;
        z = ANG_W'(ang) <<< ANG_SHIFT;
        z = {{(ANG_W-SKEW_IN_W){ang[SKEW_IN_W-1]}}, ang} <<< ANG_SHIFT;
        if (z > ANG_PI) begin
            z = z - ANG_TWO_PI;
        end else if (z < -ANG_PI) begin
            z = z + ANG_TWO_PI;
        end
        res.neg = 1'b0;
        if (z > ANG_HALF_PI) begin
            z       = z - ANG_PI;
            res.neg = 1'b1;
        end else if (z < -ANG_HALF_PI) begin
            z       = z + ANG_PI;
            res.neg = 1'b1;
        end
        res.z = z[CW-1:0];
        return res;
    endfunction

    function automatic logic signed [SKD_W-1:0] skew_wrap(
        input logic signed [SKEW_IN_W-1:0] ck,
        input logic signed [SKEW_IN_W-1:0] pk
    );
        logic signed [SKD_W-1:0] d;
        d = SKD_W'(ck) - SKD_W'(pk);
        for (int i = 0; i < 3; i++) begin
            if (d > SKEW_PI) begin
                d = d - SKEW_TWO_PI;
            end else if (d < -SKEW_PI) begin
                d = d + SKEW_TWO_PI;
            end
        end
        return d;
    endfunction

    function automatic logic signed [TRIG_W-1:0] trig_round(
        input logic signed [CW-1:0] v,
        input logic                 neg
    );
        logic signed [CW+1:0] t;
        t = neg ? -(CW+2)'(v) : (CW+2)'(v);
        t = t + ((CW+2)'(1) <<< (TRIG_SHIFT - 1));
        t = t >>> TRIG_SHIFT;
        return t[TRIG_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_round(
        input logic signed [SCALE_W-1:0] s,
        input logic signed [TRIG_W-1:0]  t
    );
        logic signed [PROD_W:0] p;
        p = (PROD_W+1)'(s) * (PROD_W+1)'(t);
        p = p + ((PROD_W+1)'(1) <<< (FRAC_BITS - 1));
        p = p >>> FRAC_BITS;
        return p[COEF_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] finish(
        input logic [QBITS-1:0] q,
        input logic             sing,
        input logic             qneg,
        input logic             ovf,
        input logic             numneg,
        input logic             numnz
    );
        logic [QBITS-1:0]      m;
        logic signed [QBITS:0] s;
        logic signed [POS_W-1:0] res;
        if (ovf) begin
            m = QBITS'(1) << POS_W;
        end else begin
            m = QBITS'(({1'b0, q} + (QBITS+1)'(1)) >> 1);
        end
        s = qneg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        if (sing) begin
            res = !numnz ? '0 : (numneg ? POS_MIN : POS_MAX);
        end else if (s > (QBITS+1)'(POS_MAX)) begin
            res = POS_MAX;
        end else if (s < (QBITS+1)'(POS_MIN)) begin
            res = POS_MIN;
        end else begin
            res = s[POS_W-1:0];
        end
        return res;
    endfunction

    logic    accept;
    t_angle  angx;
    t_angle  angy;

    logic    r_vld_c [0:TRIG_ITERATIONS];
    t_side   r_side  [0:TRIG_ITERATIONS];
    t_cordic cvx     [0:TRIG_ITERATIONS];
    t_cordic cvy     [0:TRIG_ITERATIONS];
    t_cordic r_cvx0;
    t_cordic r_cvy0;

    logic                     r_vld_p1;
    t_side                    r_side_p1;
    logic signed [TRIG_W-1:0] r_cosx;
    logic signed [TRIG_W-1:0] r_sinx;
    logic signed [TRIG_W-1:0] r_cosy;
    logic signed [TRIG_W-1:0] r_siny;

    logic                     r_vld_p2;
    t_side                    r_side_p2;
    logic signed [COEF_W-1:0] r_a;
    logic signed [COEF_W-1:0] r_b;
    logic signed [COEF_W-1:0] r_c;
    logic signed [COEF_W-1:0] r_d;

    logic                              r_vld_p3;
    t_side                             r_side_p3;
    logic signed [2*COEF_W-1:0]        r_ad;
    logic signed [2*COEF_W-1:0]        r_bc;
    logic signed [COEF_W+DIFF_W-1:0]   r_ddx;
    logic signed [COEF_W+DIFF_W-1:0]   r_cdy;
    logic signed [COEF_W+DIFF_W-1:0]   r_ady;
    logic signed [COEF_W+DIFF_W-1:0]   r_bdx;

    logic                    r_vld_p4;
    t_side                   r_side_p4;
    logic signed [DET_W-1:0] r_det;
    logic signed [NUM_W-1:0] r_nx;
    logic signed [NUM_W-1:0] r_ny;

    logic [NUM_W-1:0] nmagx;
    logic [NUM_W-1:0] nmagy;
    logic [DET_W-1:0] dmag;

    logic  r_vld_d [0:QBITS];
    t_tail r_tail  [0:QBITS];
    t_div  dvx     [0:QBITS];
    t_div  dvy     [0:QBITS];
    t_div  r_dvx0;
    t_div  r_dvy0;

    logic                         r_o_valid;
    logic signed [POS_W-1:0]      r_o_x;
    logic signed [POS_W-1:0]      r_o_y;
    logic signed [SKEW_OUT_W-1:0] r_o_skx;
    logic signed [SKEW_OUT_W-1:0] r_o_sky;
    logic                         r_o_sing;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign angx   = angle_prep(i_parent_skew_x);
    assign angy   = angle_prep(i_parent_skew_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c[0] <= 1'b0;
        end else begin
            r_vld_c[0] <= accept;
        end
        r_cvx0       <= '{x: CORDIC_GAIN, y: '0, z: angx.z};
        r_cvy0       <= '{x: CORDIC_GAIN, y: '0, z: angy.z};
        r_side[0].negx <= angx.neg;
        r_side[0].negy <= angy.neg;
        r_side[0].sx   <= i_parent_scale_x;
        r_side[0].sy   <= i_parent_scale_y;
        r_side[0].dx   <= DIFF_W'(i_child_x) - DIFF_W'(i_parent_x);
        r_side[0].dy   <= DIFF_W'(i_child_y) - DIFF_W'(i_parent_y);
        r_side[0].skx  <= skew_wrap(i_child_skew_x, i_parent_skew_x);
        r_side[0].sky  <= skew_wrap(i_child_skew_y, i_parent_skew_y);
    end

    assign cvx[0] = r_cvx0;
    assign cvy[0] = r_cvy0;

    for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_cordic
        psat_cordic_cell u_cell_x (
            .i_clk  (i_clk),
            .i_iter (ITER_W'(g)),
            .i_vec  (cvx[g]),
            .o_vec  (cvx[g+1])
        );
        psat_cordic_cell u_cell_y (
            .i_clk  (i_clk),
            .i_iter (ITER_W'(g)),
            .i_vec  (cvy[g]),
            .o_vec  (cvy[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_c[g+1] <= 1'b0;
            end else begin
                r_vld_c[g+1] <= r_vld_c[g];
            end
            r_side[g+1] <= r_side[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p1 <= 1'b0;
            r_vld_p2 <= 1'b0;
            r_vld_p3 <= 1'b0;
            r_vld_p4 <= 1'b0;
        end else begin
            r_vld_p1 <= r_vld_c[TRIG_ITERATIONS];
            r_vld_p2 <= r_vld_p1;
            r_vld_p3 <= r_vld_p2;
            r_vld_p4 <= r_vld_p3;
        end
        r_side_p1 <= r_side[TRIG_ITERATIONS];
        r_cosx    <= trig_round(cvx[TRIG_ITERATIONS].x, r_side[TRIG_ITERATIONS].negx);
        r_sinx    <= trig_round(cvx[TRIG_ITERATIONS].y, r_side[TRIG_ITERATIONS].negx);
        r_cosy    <= trig_round(cvy[TRIG_ITERATIONS].x, r_side[TRIG_ITERATIONS].negy);
        r_siny    <= trig_round(cvy[TRIG_ITERATIONS].y, r_side[TRIG_ITERATIONS].negy);

        r_side_p2 <= r_side_p1;
        r_a       <= coef_round(r_side_p1.sx, r_cosy);
        r_b       <= coef_round(r_side_p1.sx, r_siny);
        r_c       <= -coef_round(r_side_p1.sy, r_sinx);
        r_d       <= coef_round(r_side_p1.sy, r_cosx);

        r_side_p3 <= r_side_p2;
        r_ad      <= (2*COEF_W)'(r_a) * (2*COEF_W)'(r_d);
        r_bc      <= (2*COEF_W)'(r_b) * (2*COEF_W)'(r_c);
        r_ddx     <= (COEF_W+DIFF_W)'(r_d) * (COEF_W+DIFF_W)'(r_side_p2.dx);
        r_cdy     <= (COEF_W+DIFF_W)'(r_c) * (COEF_W+DIFF_W)'(r_side_p2.dy);
        r_ady     <= (COEF_W+DIFF_W)'(r_a) * (COEF_W+DIFF_W)'(r_side_p2.dy);
        r_bdx     <= (COEF_W+DIFF_W)'(r_b) * (COEF_W+DIFF_W)'(r_side_p2.dx);

        r_side_p4 <= r_side_p3;
        r_det     <= DET_W'(r_ad - r_bc);
        r_nx      <= NUM_W'(r_ddx - r_cdy);
        r_ny      <= NUM_W'(r_ady - r_bdx);
    end

    assign nmagx = r_nx[NUM_W-1] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
    assign nmagy = r_ny[NUM_W-1] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
    assign dmag  = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d[0] <= 1'b0;
        end else begin
            r_vld_d[0] <= r_vld_p4;
        end
        r_tail[0].sing    <= (r_det == '0);
        r_tail[0].qnegx   <= r_nx[NUM_W-1] != r_det[DET_W-1];
        r_tail[0].qnegy   <= r_ny[NUM_W-1] != r_det[DET_W-1];
        r_tail[0].ovfx    <= (DET_W+POS_W)'(nmagx) >= {dmag, POS_W'(0)};
        r_tail[0].ovfy    <= (DET_W+POS_W)'(nmagy) >= {dmag, POS_W'(0)};
        r_tail[0].numnegx <= r_nx[NUM_W-1];
        r_tail[0].numnzx  <= (r_nx != '0);
        r_tail[0].numnegy <= r_ny[NUM_W-1];
        r_tail[0].numnzy  <= (r_ny != '0);
        r_tail[0].skx     <= r_side_p4.skx;
        r_tail[0].sky     <= r_side_p4.sky;
        r_dvx0.r  <= DET_W'(nmagx >> POS_W);
        r_dvx0.nq <= {nmagx[POS_W-1:0], (IO_FRAC+1)'(0)};
        r_dvx0.dd <= dmag;
        r_dvy0.r  <= DET_W'(nmagy >> POS_W);
        r_dvy0.nq <= {nmagy[POS_W-1:0], (IO_FRAC+1)'(0)};
        r_dvy0.dd <= dmag;
    end

    assign dvx[0] = r_dvx0;
    assign dvy[0] = r_dvy0;

    for (genvar g = 0; g < QBITS; g++) begin : g_div
        psat_div_cell u_div_x (
            .i_clk (i_clk),
            .i_div (dvx[g]),
            .o_div (dvx[g+1])
        );
        psat_div_cell u_div_y (
            .i_clk (i_clk),
            .i_div (dvy[g]),
            .o_div (dvy[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_d[g+1] <= 1'b0;
            end else begin
                r_vld_d[g+1] <= r_vld_d[g];
            end
            r_tail[g+1] <= r_tail[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_vld_d[QBITS];
        end
        r_o_x    <= finish(dvx[QBITS].nq, r_tail[QBITS].sing, r_tail[QBITS].qnegx,
                           r_tail[QBITS].ovfx, r_tail[QBITS].numnegx, r_tail[QBITS].numnzx);
        r_o_y    <= finish(dvy[QBITS].nq, r_tail[QBITS].sing, r_tail[QBITS].qnegy,
                           r_tail[QBITS].ovfy, r_tail[QBITS].numnegy, r_tail[QBITS].numnzy);
        r_o_skx  <= r_tail[QBITS].skx[SKEW_OUT_W-1:0];
        r_o_sky  <= r_tail[QBITS].sky[SKEW_OUT_W-1:0];
        r_o_sing <= r_tail[QBITS].sing;
    end

    assign o_valid        = r_o_valid;
    assign o_local_x      = r_o_x;
    assign o_local_y      = r_o_y;
    assign o_local_skew_x = r_o_skx;
    assign o_local_skew_y = r_o_sky;
    assign o_singular     = r_o_sing;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("Accepted item did not produce a result after the pipeline latency.");

    a_skew_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_local_skew_x <= SKEW_OUT_W'(SKEW_PI)
                     && o_local_skew_x >= -SKEW_OUT_W'(SKEW_PI)))
        else $error("Skew x result lies outside the wrapped range.");

    a_skew_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_local_skew_y <= SKEW_OUT_W'(SKEW_PI)
                     && o_local_skew_y >= -SKEW_OUT_W'(SKEW_PI)))
        else $error("Skew y result lies outside the wrapped range.");

    a_singular_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> ((o_local_x == POS_MAX || o_local_x == POS_MIN
                                      || o_local_x == '0)
                                     && (o_local_y == POS_MAX || o_local_y == POS_MIN
                                      || o_local_y == '0)))
        else $error("Singular result is not saturated.");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the parent-space affine transform unit.
`timescale 1ns / 100ps

module testbench;

    import psat_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0]     cx, cy;
        logic signed [SKEW_IN_W-1:0] ckx, cky;
        logic signed [SCALE_W-1:0]   sx, sy;
        logic signed [SKEW_IN_W-1:0] pkx, pky;
        logic signed [POS_W-1:0]     tx, ty;
        bit                          drain;
    } xform_item_t;

    typedef struct {
        logic signed [POS_W-1:0]      lx, ly;
        logic signed [SKEW_OUT_W-1:0] skx, sky;
        logic                         sing;
    } local_pose_t;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint SKW_PI      = 64'sd205887;
    localparam longint SKW_TWO_PI  = 64'sd411775;
    localparam longint I32_MAX     = 64'sd2147483647;
    localparam longint I32_MIN     = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [POS_W-1:0]     i_child_x = '0, i_child_y = '0;
    logic signed [SKEW_IN_W-1:0] i_child_skew_x = '0, i_child_skew_y = '0;
    logic signed [SCALE_W-1:0]   i_parent_scale_x = '0, i_parent_scale_y = '0;
    logic signed [SKEW_IN_W-1:0] i_parent_skew_x = '0, i_parent_skew_y = '0;
    logic signed [POS_W-1:0]     i_parent_x = '0, i_parent_y = '0;
    logic                         o_valid;
    logic signed [POS_W-1:0]      o_local_x, o_local_y;
    logic signed [SKEW_OUT_W-1:0] o_local_skew_x, o_local_skew_y;
    logic                         o_singular;

    xform_item_t pending_items[$];
    local_pose_t expected_poses[$];
    xform_item_t in_flight;
    int          mismatches = 0;
    bit          idle_free = 1'b0;

    parent_space_affine_transform_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_child_x(i_child_x), .i_child_y(i_child_y),
        .i_child_skew_x(i_child_skew_x), .i_child_skew_y(i_child_skew_y),
        .i_parent_scale_x(i_parent_scale_x), .i_parent_scale_y(i_parent_scale_y),
        .i_parent_skew_x(i_parent_skew_x), .i_parent_skew_y(i_parent_skew_y),
        .i_parent_x(i_parent_x), .i_parent_y(i_parent_y),
        .o_valid(o_valid), .o_local_x(o_local_x), .o_local_y(o_local_y),
        .o_local_skew_x(o_local_skew_x), .o_local_skew_y(o_local_skew_y),
        .o_singular(o_singular)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void sin_cos(input longint ang, output longint sn,
                                    output longint cs);
        longint z, x, y, t;
        bit     flip;
        z = ang * (64'sd1 <<< (30 - IO_FRAC));
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        while (z > PI_Q30) z -= TWO_PI_Q30;
        while (z < -PI_Q30) z += TWO_PI_Q30;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_ITERATIONS && i < ATAN_ENTRIES; i++) begin
            longint at;
            at = longint'(atan_entry(ITER_W'(i)));
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= at;
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += at;
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = rnd_shift(x, 30 - FRAC_BITS);
        sn = rnd_shift(y, 30 - FRAC_BITS);
    endfunction

    function automatic longint quotient_q16(longint num, longint den);
        bit              negr;
        longint unsigned n, dd, q, r;
        longint          m;
        negr = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        dd = (den < 0) ? -den : den;
        q = n / dd;
        r = n % dd;
        if (q >= (64'd1 << 32)) begin
            m = 64'sd1 <<< 32;
        end else begin
            for (int k = 0; k < IO_FRAC + 1; k++) begin
                r = r << 1;
                q = q << 1;
                if (r >= dd) begin
                    r -= dd;
                    q |= 1;
                end
            end
            m = longint'((q + 1) >> 1);
        end
        if (negr) m = -m;
        if (m > I32_MAX) return I32_MAX;
        if (m < I32_MIN) return I32_MIN;
        return m;
    endfunction

    function automatic longint wrap_angle(longint d);
        while (d > SKW_PI) d -= SKW_TWO_PI;
        while (d < -SKW_PI) d += SKW_TWO_PI;
        return d;
    endfunction

    function automatic longint sign_limit(longint v);
        if (v > 0) return I32_MAX;
        if (v < 0) return I32_MIN;
        return 0;
    endfunction

    function automatic local_pose_t predict_pose(xform_item_t it);
        longint      snx, csx, sny, csy, a, b, c, d, det, dx, dy, nx, ny;
        local_pose_t p;
        sin_cos(longint'(it.pkx), snx, csx);
        sin_cos(longint'(it.pky), sny, csy);
        a = rnd_shift(longint'(it.sx) * csy, FRAC_BITS);
        b = rnd_shift(longint'(it.sx) * sny, FRAC_BITS);
        c = -rnd_shift(longint'(it.sy) * snx, FRAC_BITS);
        d = rnd_shift(longint'(it.sy) * csx, FRAC_BITS);
        det = a * d - b * c;
        dx = longint'(it.cx) - longint'(it.tx);
        dy = longint'(it.cy) - longint'(it.ty);
        nx = d * dx - c * dy;
        ny = a * dy - b * dx;
        p.sing = (det == 0);
        if (p.sing) begin
            p.lx = POS_W'(sign_limit(nx));
            p.ly = POS_W'(sign_limit(ny));
        end else begin
            p.lx = POS_W'(quotient_q16(nx, det));
            p.ly = POS_W'(quotient_q16(ny, det));
        end
        p.skx = SKEW_OUT_W'(wrap_angle(longint'(it.ckx) - longint'(it.pkx)));
        p.sky = SKEW_OUT_W'(wrap_angle(longint'(it.cky) - longint'(it.pky)));
        return p;
    endfunction

    function automatic xform_item_t random_item();
        xform_item_t it;
        it.cx = $urandom; it.cy = $urandom; it.tx = $urandom; it.ty = $urandom;
        it.ckx = SKEW_IN_W'($urandom); it.cky = SKEW_IN_W'($urandom);
        it.pkx = SKEW_IN_W'($urandom); it.pky = SKEW_IN_W'($urandom);
        it.sx = SCALE_W'($urandom); it.sy = SCALE_W'($urandom);
        it.drain = 1'b0;
        if ($urandom_range(99) < 65) begin
            // Plausible scene transforms: modest scales and positions.
            it.sx = $signed(24'($urandom_range(262144))) - 24'sd131072;
            it.sy = $signed(24'($urandom_range(262144))) - 24'sd131072;
            it.cx = $signed(32'($urandom_range(33554432))) - 32'sd16777216;
            it.cy = $signed(32'($urandom_range(33554432))) - 32'sd16777216;
            it.tx = $signed(32'($urandom_range(33554432))) - 32'sd16777216;
            it.ty = $signed(32'($urandom_range(33554432))) - 32'sd16777216;
            if ($urandom_range(9) == 0) it.sx = '0;
            if ($urandom_range(9) == 0) it.sy = $signed(24'($urandom_range(3))) - 24'sd1;
        end
        return it;
    endfunction

    function automatic xform_item_t make_item(longint cx, longint cy, longint ckx,
                                              longint cky, longint sx, longint sy,
                                              longint pkx, longint pky, longint tx,
                                              longint ty);
        xform_item_t it;
        it.cx = POS_W'(cx); it.cy = POS_W'(cy);
        it.ckx = SKEW_IN_W'(ckx); it.cky = SKEW_IN_W'(cky);
        it.sx = SCALE_W'(sx); it.sy = SCALE_W'(sy);
        it.pkx = SKEW_IN_W'(pkx); it.pky = SKEW_IN_W'(pky);
        it.tx = POS_W'(tx); it.ty = POS_W'(ty);
        it.drain = 1'b0;
        return it;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s at %0t: expected %0d, got %0d",
                         name, $time, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) expected_poses.push_back(predict_pose(in_flight));
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_items.size() > 0
                         && (idle_free || $urandom_range(99) >= 28)
                         && !(pending_items[0].drain
                              && (expected_poses.size() > 0 || start))) begin
                in_flight = pending_items.pop_front();
                i_child_x <= in_flight.cx;
                i_child_y <= in_flight.cy;
                i_child_skew_x <= in_flight.ckx;
                i_child_skew_y <= in_flight.cky;
                i_parent_scale_x <= in_flight.sx;
                i_parent_scale_y <= in_flight.sy;
                i_parent_skew_x <= in_flight.pkx;
                i_parent_skew_y <= in_flight.pky;
                i_parent_x <= in_flight.tx;
                i_parent_y <= in_flight.ty;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at %0t", $time);
            end else begin
                local_pose_t want;
                want = expected_poses.pop_front();
                check_field("local_x", want.lx, o_local_x);
                check_field("local_y", want.ly, o_local_y);
                check_field("local_skew_x", want.skx, o_local_skew_x);
                check_field("local_skew_y", want.sky, o_local_skew_y);
                check_field("singular", want.sing, o_singular);
            end
        end
    end

    initial begin
        xform_item_t it;
        // Directed: field extremes, identity, singular parents, skew wrap corners.
        pending_items.push_back(make_item(0, 0, 0, 0, 65536, 65536, 0, 0, 0, 0));
        pending_items.push_back(make_item(65536, -65536, 0, 0, 65536, 65536, 0, 0, 0, 0));
        pending_items.push_back(make_item(I32_MAX, I32_MAX, 524287, 524287, 8388607,
                                          8388607, 524287, 524287, I32_MAX, I32_MAX));
        pending_items.push_back(make_item(I32_MIN, I32_MIN, -524288, -524288, -8388608,
                                          -8388608, -524288, -524288, I32_MIN, I32_MIN));
        pending_items.push_back(make_item(I32_MAX, I32_MIN, 524287, -524288, 1, 1,
                                          -524288, 524287, I32_MIN, I32_MAX));
        pending_items.push_back(make_item(I32_MIN, I32_MAX, -524288, 524287, 1, -1,
                                          0, 0, I32_MAX, I32_MIN));
        pending_items.push_back(make_item(1000, -1000, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(5, 5, 0, 0, 0, 65536, 1000, 2000, 0, 0));
        pending_items.push_back(make_item(-7, 3, 0, 0, 65536, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(123456, 654321, 205887, -205887, 65536, 65536,
                                          -205887, 205887, 0, 0));
        pending_items.push_back(make_item(65536, 65536, 205888, -205888, 131072, 32768,
                                          102943, -102943, 4096, -4096));
        pending_items.push_back(make_item(65536, 65536, 102944, 102944, 65536, 65536,
                                          102944, -102944, 0, 0));
        pending_items.push_back(make_item(I32_MAX, 0, 0, 0, 1, 1, 102944, 0, I32_MIN, 0));
        pending_items.push_back(make_item(9999, -9999, 311, -311, 8388607, -8388608,
                                          314159, -314159, -1, 1));
        pending_items.push_back(make_item(-65536, 32768, 411775, -411775, -65536, 65536,
                                          411775, 0, 65536, 65536));
        pending_items.push_back(make_item(1, 1, 0, 0, 1, 1, 51472, 51472, 0, 0));
        for (int n = 0; n < 1100; n++) begin
            it = random_item();
            if (n == 300 || n == 800) it.drain = 1'b1;
            pending_items.push_back(it);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (400) @(posedge i_clk);
        idle_free = 1'b1;
        repeat (250) @(posedge i_clk);
        idle_free = 1'b0;
        while (pending_items.size() > 0) @(posedge i_clk);
        @(posedge i_clk);
        while (start || expected_poses.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_poses.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
